/* sv/two_body_gravity_euler_step_top_defines.svh */
// ----------------------------------------------------------------------------
// Two-body gravity Euler step: assertion macros
// Shared assertion forms for the checker of the integrator block.
// ----------------------------------------------------------------------------
`ifndef TWO_BODY_GRAVITY_EULER_STEP_TOP_DEFINES_SVH
`define TWO_BODY_GRAVITY_EULER_STEP_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TBGE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbge check failed");

// Consequent checked in the cycle after the antecedent.
`define TBGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbge check failed");

`endif

/* sv/tbge_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body gravity Euler step package
// Types, sequencer codes, reset values and saturating helpers.
// ----------------------------------------------------------------------------
package tbge_pkg;

    localparam int CFG_W = 31;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_MASS_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_MASS_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_GRAV   = 2'd2;
    localparam logic [IDX_W-1:0] REG_STEP   = 2'd3;

    localparam logic [CFG_W-1:0] MASS_RST = 31'd65536;
    localparam logic [CFG_W-1:0] GRAV_RST = 31'd65536;
    localparam logic [CFG_W-1:0] STEP_RST = 31'd6554;
    localparam logic [CFG_W-1:0] K_MAX    = 31'h7fff_ffff;

    localparam logic signed [31:0] POS_A_RST = 32'sd65536;
    localparam logic signed [31:0] POS_B_RST = 32'sd131072;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fff_ffff;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DIV   = 5'b00100,
        S_SQRT  = 5'b01000,
        S_WB    = 5'b10000
    } state_t;

    typedef logic [4:0] op_t;

    localparam op_t OP_DIFF = 5'd0;
    localparam op_t OP_DPXA = 5'd1;
    localparam op_t OP_DPYA = 5'd2;
    localparam op_t OP_DPXB = 5'd3;
    localparam op_t OP_DPYB = 5'd4;
    localparam op_t OP_SQX  = 5'd5;
    localparam op_t OP_SQY  = 5'd6;
    localparam op_t OP_SQRT = 5'd7;
    localparam op_t OP_K1   = 5'd8;
    localparam op_t OP_K2   = 5'd9;
    localparam op_t OP_Q1   = 5'd10;
    localparam op_t OP_Q2   = 5'd11;
    localparam op_t OP_UX   = 5'd12;
    localparam op_t OP_FX   = 5'd13;
    localparam op_t OP_UY   = 5'd14;
    localparam op_t OP_FY   = 5'd15;
    localparam op_t OP_MAX  = 5'd16;
    localparam op_t OP_DAX  = 5'd17;
    localparam op_t OP_MAY  = 5'd18;
    localparam op_t OP_DAY  = 5'd19;
    localparam op_t OP_MBX  = 5'd20;
    localparam op_t OP_DBX  = 5'd21;
    localparam op_t OP_MBY  = 5'd22;
    localparam op_t OP_DBY  = 5'd23;
    localparam op_t OP_FIN  = 5'd24;

    // Applies a sign to a magnitude and clamps to 32-bit signed.
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            if (mag > 64'h8000_0000)
                res = S32_MIN;
            else
                res = $signed(~mag[31:0] + 32'd1);
        end else begin
            if (mag > 64'h7fff_ffff)
                res = S32_MAX;
            else
                res = $signed(mag[31:0]);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31])
            res = v[32] ? S32_MIN : S32_MAX;
        else
            res = v[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

/* sv/tbge_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body gravity Euler step channels
// Valid/ready channels for the step request and the force result.
// ----------------------------------------------------------------------------
interface tbge_step_if;
    logic valid;
    logic ready;
    logic step_go;

    modport source (output valid, output step_go, input ready);
    modport sink   (input valid, input step_go, output ready);
endinterface

interface tbge_force_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               coincident;

    modport source (output valid, output force_x, output force_y, output coincident,
                    input ready);
    modport sink   (input valid, input force_x, input force_y, input coincident,
                    output ready);
endinterface

/* sv/two_body_gravity_euler_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body gravity explicit Euler integrator
// One Euler step per accepted step_go word, Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  channel    dir   word
//  step_ch    in    step_go
//  force_ch   out   force_x, force_y, coincident
//  cfg        in    cfg_wen, cfg_index, cfg_data (write only)
//
// A step uses eight passes of the shared restoring divider and the square
// root, with one shared 33x33 multiplier between; a step with coincident
// particles ends after the position update. step_ch is ready only while
// idle; a finished word waits in the output register and the next step may
// already start. Reset restores sequencer, configuration and particle state.
module two_body_gravity_euler_step_top (
    input  logic                     clk,
    input  logic                     rst_n,
    tbge_step_if.sink                step_ch,
    tbge_force_if.source             force_ch,
    input  logic                     cfg_wen,
    input  logic [tbge_pkg::IDX_W-1:0] cfg_index,
    input  logic [tbge_pkg::CFG_W-1:0] cfg_data
);
    import tbge_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [CFG_W-1:0] ma_reg, mb_reg, g_reg, h_reg;

    logic signed [31:0] pxa_reg, pya_reg, pxb_reg, pyb_reg;
    logic signed [31:0] pxa_next, pya_next, pxb_next, pyb_next;
    logic signed [31:0] vxa_reg, vya_reg, vxb_reg, vyb_reg;
    logic signed [31:0] vxa_next, vya_next, vxb_next, vyb_next;

    logic signed [31:0] dx_reg, dy_reg, dx_next, dy_next;
    logic               coin_reg, coin_next;
    logic [63:0]        sq_reg, sq_next;
    logic [31:0]        r_reg, r_next;
    logic [CFG_W-1:0]   k_reg, k_next;
    logic [46:0]        q_reg, q_next;
    logic [16:0]        u_reg, u_next;
    logic signed [31:0] fx_reg, fy_reg, fx_next, fy_next;
    logic [65:0]        prod_reg, prod_next;
    logic [63:0]        dvd_reg, dvd_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic [32:0]        rem_reg, rem_next;

    logic               ov_reg, ov_next;
    logic signed [31:0] ofx_reg, ofy_reg, ofx_next, ofy_next;
    logic               ocoin_reg, ocoin_next;

    logic [32:0] mul_a, mul_b;
    logic [63:0] ld_dvd;
    logic [31:0] ld_dvs;
    logic [31:0] abs_dx, abs_dy, fax_mag, fay_mag;
    logic        fax_neg, fay_neg;
    logic [31:0] ma_div, mb_div;
    logic signed [31:0] dx_calc, dy_calc;
    logic [32:0] div_t, div_diff;
    logic        div_ge;
    logic [34:0] sr_t, sr_trial;
    logic        sr_ge;
    logic [63:0] prod_hi;
    op_t         op_inc;

    assign step_ch.ready       = (state_reg == S_IDLE);
    assign force_ch.valid      = ov_reg;
    assign force_ch.force_x    = ofx_reg;
    assign force_ch.force_y    = ofy_reg;
    assign force_ch.coincident = ocoin_reg;

    always_comb
    begin
        abs_dx  = abs32(dx_reg);
        abs_dy  = abs32(dy_reg);
        // Force on particle a is the negated force on b, saturated.
        fax_mag = (fx_reg == S32_MIN) ? 32'h7fff_ffff : abs32(fx_reg);
        fay_mag = (fy_reg == S32_MIN) ? 32'h7fff_ffff : abs32(fy_reg);
        fax_neg = !fx_reg[31] && (fx_reg != 32'sd0);
        fay_neg = !fy_reg[31] && (fy_reg != 32'sd0);
        ma_div  = (ma_reg == '0) ? 32'd1 : {1'b0, ma_reg};
        mb_div  = (mb_reg == '0) ? 32'd1 : {1'b0, mb_reg};
        dx_calc = sat33({pxa_reg[31], pxa_reg} - {pxb_reg[31], pxb_reg});
        dy_calc = sat33({pya_reg[31], pya_reg} - {pyb_reg[31], pyb_reg});
        prod_hi = {14'd0, prod_reg[65:16]};
        op_inc  = op_t'(op_reg + 5'd1);

        div_t    = {rem_reg[31:0], dvd_reg[63]};
        div_ge   = (div_t >= {1'b0, dvs_reg});
        div_diff = div_t - {1'b0, dvs_reg};

        sr_t     = {rem_reg, dvd_reg[63:62]};
        sr_trial = {1'b0, r_reg, 2'b01};
        sr_ge    = (sr_t >= sr_trial);
    end

    always_comb
    begin
        case (op_reg)
            OP_DPXA: begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(vxa_reg)}; end
            OP_DPYA: begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(vya_reg)}; end
            OP_DPXB: begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(vxb_reg)}; end
            OP_DPYB: begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(vyb_reg)}; end
            OP_SQX:  begin mul_a = {1'b0, abs_dx}; mul_b = {1'b0, abs_dx}; end
            OP_SQY:  begin mul_a = {1'b0, abs_dy}; mul_b = {1'b0, abs_dy}; end
            OP_K1:   begin mul_a = {2'b0, g_reg}; mul_b = {2'b0, ma_reg}; end
            OP_K2:   begin mul_a = {2'b0, k_reg}; mul_b = {2'b0, mb_reg}; end
            OP_FX:   begin mul_a = q_reg[32:0]; mul_b = {16'd0, u_reg}; end
            OP_FY:   begin mul_a = q_reg[32:0]; mul_b = {16'd0, u_reg}; end
            OP_MAX:  begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, fax_mag}; end
            OP_MAY:  begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, fay_mag}; end
            OP_MBX:  begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(fx_reg)}; end
            OP_MBY:  begin mul_a = {2'b0, h_reg}; mul_b = {1'b0, abs32(fy_reg)}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_Q1:   begin ld_dvd = {17'd0, k_reg, 16'd0}; ld_dvs = r_reg; end
            OP_Q2:   begin ld_dvd = {1'b0, q_reg, 16'd0}; ld_dvs = r_reg; end
            OP_UX:   begin ld_dvd = {16'd0, abs_dx, 16'd0}; ld_dvs = r_reg; end
            OP_UY:   begin ld_dvd = {16'd0, abs_dy, 16'd0}; ld_dvs = r_reg; end
            OP_DAX:  begin ld_dvd = prod_reg[63:0]; ld_dvs = ma_div; end
            OP_DAY:  begin ld_dvd = prod_reg[63:0]; ld_dvs = ma_div; end
            OP_DBX:  begin ld_dvd = prod_reg[63:0]; ld_dvs = mb_div; end
            OP_DBY:  begin ld_dvd = prod_reg[63:0]; ld_dvs = mb_div; end
            default: begin ld_dvd = '0; ld_dvs = 32'd1; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        pxa_next = pxa_reg; pya_next = pya_reg; pxb_next = pxb_reg; pyb_next = pyb_reg;
        vxa_next = vxa_reg; vya_next = vya_reg; vxb_next = vxb_reg; vyb_next = vyb_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        coin_next = coin_reg;
        sq_next   = sq_reg;
        r_next    = r_reg;
        k_next    = k_reg;
        q_next    = q_reg;
        u_next    = u_reg;
        fx_next   = fx_reg;
        fy_next   = fy_reg;
        prod_next = prod_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        ofx_next   = ofx_reg;
        ofy_next   = ofy_reg;
        ocoin_next = ocoin_reg;
        ov_next    = ov_reg && !force_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (step_ch.valid && step_ch.step_go)
                begin
                    op_next    = OP_DIFF;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                case (op_reg)
                    OP_DIFF:
                    begin
                        dx_next   = dx_calc;
                        dy_next   = dy_calc;
                        coin_next = (dx_calc == 32'sd0) && (dy_calc == 32'sd0);
                        fx_next   = 32'sd0;
                        fy_next   = 32'sd0;
                        op_next   = op_inc;
                    end
                    OP_SQRT:
                    begin
                        dvd_next   = sq_reg;
                        rem_next   = '0;
                        r_next     = '0;
                        cnt_next   = 6'd31;
                        state_next = S_SQRT;
                    end
                    OP_Q1, OP_Q2, OP_UX, OP_UY, OP_DAX, OP_DAY, OP_DBX, OP_DBY:
                    begin
                        dvd_next   = ld_dvd;
                        dvs_next   = ld_dvs;
                        rem_next   = '0;
                        cnt_next   = 6'd63;
                        state_next = S_DIV;
                    end
                    OP_FIN:
                    begin
                        if (!ov_reg || force_ch.ready)
                        begin
                            ov_next    = 1'b1;
                            ofx_next   = fx_reg;
                            ofy_next   = fy_reg;
                            ocoin_next = coin_reg;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        prod_next  = mul_a * mul_b;
                        state_next = S_WB;
                    end
                endcase
            end
            S_DIV:
            begin
                // One quotient bit per cycle, shifted into the dividend register.
                rem_next = div_ge ? {1'b0, div_diff[31:0]} : {1'b0, div_t[31:0]};
                dvd_next = {dvd_reg[62:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                    state_next = S_WB;
            end
            S_SQRT:
            begin
                // One root bit per cycle, two radicand bits consumed.
                rem_next = sr_ge ? 33'(sr_t - sr_trial) : sr_t[32:0];
                r_next   = {r_reg[30:0], sr_ge};
                dvd_next = {dvd_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    op_next    = op_inc;
                    state_next = S_ISSUE;
                end
            end
            S_WB:
            begin
                op_next    = op_inc;
                state_next = S_ISSUE;
                case (op_reg)
                    OP_DPXA: pxa_next = add_sat(pxa_reg, sat_mag(vxa_reg[31], prod_hi));
                    OP_DPYA: pya_next = add_sat(pya_reg, sat_mag(vya_reg[31], prod_hi));
                    OP_DPXB: pxb_next = add_sat(pxb_reg, sat_mag(vxb_reg[31], prod_hi));
                    OP_DPYB:
                    begin
                        pyb_next = add_sat(pyb_reg, sat_mag(vyb_reg[31], prod_hi));
                        // Coincident particles keep their velocities.
                        if (coin_reg)
                            op_next = OP_FIN;
                    end
                    OP_SQX: sq_next = prod_reg[63:0];
                    OP_SQY: sq_next = sq_reg + prod_reg[63:0];
                    OP_K1, OP_K2:
                        k_next = (|prod_reg[65:47]) ? K_MAX : prod_reg[46:16];
                    OP_Q1: q_next = dvd_reg[46:0];
                    OP_Q2: q_next = (dvd_reg > 64'h1_0000_0000) ? 47'h1_0000_0000
                                                                : dvd_reg[46:0];
                    OP_UX, OP_UY: u_next = dvd_reg[16:0];
                    OP_FX: fx_next = sat_mag(dx_reg[31], prod_hi);
                    OP_FY: fy_next = sat_mag(dy_reg[31], prod_hi);
                    OP_DAX: vxa_next = add_sat(vxa_reg, sat_mag(fax_neg, dvd_reg));
                    OP_DAY: vya_next = add_sat(vya_reg, sat_mag(fay_neg, dvd_reg));
                    OP_DBX: vxb_next = add_sat(vxb_reg, sat_mag(fx_reg[31], dvd_reg));
                    OP_DBY: vyb_next = add_sat(vyb_reg, sat_mag(fy_reg[31], dvd_reg));
                    default: ;
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_DIFF;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            ma_reg    <= MASS_RST;
            mb_reg    <= MASS_RST;
            g_reg     <= GRAV_RST;
            h_reg     <= STEP_RST;
            pxa_reg   <= POS_A_RST;
            pya_reg   <= POS_A_RST;
            pxb_reg   <= POS_B_RST;
            pyb_reg   <= POS_B_RST;
            vxa_reg   <= '0;
            vya_reg   <= '0;
            vxb_reg   <= '0;
            vyb_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            pxa_reg   <= pxa_next;
            pya_reg   <= pya_next;
            pxb_reg   <= pxb_next;
            pyb_reg   <= pyb_next;
            vxa_reg   <= vxa_next;
            vya_reg   <= vya_next;
            vxb_reg   <= vxb_next;
            vyb_reg   <= vyb_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_MASS_A: ma_reg <= cfg_data;
                    REG_MASS_B: mb_reg <= cfg_data;
                    REG_GRAV:   g_reg  <= cfg_data;
                    REG_STEP:   h_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        coin_reg  <= coin_next;
        sq_reg    <= sq_next;
        r_reg     <= r_next;
        k_reg     <= k_next;
        q_reg     <= q_next;
        u_reg     <= u_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        prod_reg  <= prod_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        ocoin_reg <= ocoin_next;
    end

endmodule

/* sv/tbge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body gravity Euler step checker
// Port-level assertions, bound to the integrator top level.
// ----------------------------------------------------------------------------
`include "two_body_gravity_euler_step_top_defines.svh"

module tbge_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               step_valid,
    input logic               step_ready,
    input logic               step_go,
    input logic               force_valid,
    input logic               force_ready,
    input logic signed [31:0] force_x,
    input logic signed [31:0] force_y,
    input logic               coincident
);
    // Coincident particles must report zero force.
    `TBGE_ASSERT_SAME(a_coin_zero, clk, rst_n, force_valid && coincident, (force_x == 32'sd0) && (force_y == 32'sd0))

    // A real step keeps the block busy on the next cycle.
    `TBGE_ASSERT_NEXT(a_step_busy, clk, rst_n, step_valid && step_ready && step_go, !step_ready)

    // An empty tick leaves the block idle.
    `TBGE_ASSERT_NEXT(a_idle_tick, clk, rst_n, step_valid && step_ready && !step_go, step_ready)

    // A stalled word holds.
    `TBGE_ASSERT_NEXT(a_out_hold, clk, rst_n, force_valid && !force_ready, force_valid && $stable(force_x) && $stable(force_y) && $stable(coincident))

    // A new word appears only at the end of a step.
    `TBGE_ASSERT_SAME(a_out_after_step, clk, rst_n, $rose(force_valid), !$past(step_ready))

endmodule

bind two_body_gravity_euler_step_top tbge_checker u_tbge_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_valid  (step_ch.valid),
    .step_ready  (step_ch.ready),
    .step_go     (step_ch.step_go),
    .force_valid (force_ch.valid),
    .force_ready (force_ch.ready),
    .force_x     (force_ch.force_x),
    .force_y     (force_ch.force_y),
    .coincident  (force_ch.coincident)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-body gravity Euler step testbench
// Sends step words with random gaps, stalls the force channel at random, and
// checks every force word against an in-bench fixed-point integrator that
// tracks positions, velocities and the configuration registers.
// ----------------------------------------------------------------------------
module testbench;
    import tbge_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 700;
    localparam logic [CFG_W-1:0] REG_TOP = 31'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               coin;
    } force_word_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    tbge_step_if  step_ch();
    tbge_force_if force_ch();

    two_body_gravity_euler_step_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_ch   (step_ch),
        .force_ch  (force_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Integrator state and registers as the block should hold them.
    logic [CFG_W-1:0] m_a, m_b, g_k, h_dt;
    logic signed [31:0] pxa, pya, pxb, pyb, vxa, vya, vxb, vyb;

    force_word_t pending_forces[$];
    int  fail_count;
    int  idle_cycles;
    bit  send_burst;
    bit  recv_burst;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > longint'(S32_MAX))
            return S32_MAX;
        if (v < longint'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint apply_sign(input bit neg, input longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Force on particle b for the given positions and registers.
    function automatic force_word_t pair_force(input logic [CFG_W-1:0] g, ma, mb,
                                               input logic signed [31:0] ax, ay, bx, by);
        force_word_t w;
        longint dx, dy;
        longint unsigned r, k, q, u;
        dx = clamp32(longint'(ax) - longint'(bx));
        dy = clamp32(longint'(ay) - longint'(by));
        w.coin = (dx == 0 && dy == 0);
        w.fx = '0;
        w.fy = '0;
        if (!w.coin)
        begin
            r = int_sqrt(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy));
            k = (longint'(g) * longint'(ma)) >> 16;
            if (k > longint'(REG_TOP))
                k = REG_TOP;
            k = (k * longint'(mb)) >> 16;
            if (k > longint'(REG_TOP))
                k = REG_TOP;
            q = (k << 16) / r;
            q = (q << 16) / r;
            if (q > (64'd1 << 32))
                q = 64'd1 << 32;
            u = (magnitude(dx) << 16) / r;
            w.fx = clamp32(apply_sign(dx < 0, (q * u) >> 16));
            u = (magnitude(dy) << 16) / r;
            w.fy = clamp32(apply_sign(dy < 0, (q * u) >> 16));
        end
        return w;
    endfunction

    function automatic logic signed [31:0] vel_change(input logic signed [31:0] f,
                                                      input logic [CFG_W-1:0] m);
        longint unsigned dv, p;
        dv = (m == 0) ? 1 : m;
        p = longint'(h_dt) * magnitude(f) / dv;
        if (p > (64'd1 << 40))
            p = 64'd1 << 40;
        return clamp32(apply_sign(f < 0, p));
    endfunction

    function automatic logic signed [31:0] pos_change(input logic signed [31:0] v);
        return clamp32(apply_sign(v < 0, (longint'(h_dt) * magnitude(v)) >> 16));
    endfunction

    function automatic logic signed [31:0] acc(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return clamp32(longint'(a) + longint'(b));
    endfunction

    // Advances the integrator by one tick and queues the expected force word.
    task automatic euler_tick();
        force_word_t w;
        logic signed [31:0] fax, fay, dvxa, dvya, dvxb, dvyb;
        w = pair_force(g_k, m_a, m_b, pxa, pya, pxb, pyb);
        fax = clamp32(-longint'(w.fx));
        fay = clamp32(-longint'(w.fy));
        dvxa = vel_change(fax, m_a);
        dvya = vel_change(fay, m_a);
        dvxb = vel_change(w.fx, m_b);
        dvyb = vel_change(w.fy, m_b);
        pxa = acc(pxa, pos_change(vxa));
        pya = acc(pya, pos_change(vya));
        pxb = acc(pxb, pos_change(vxb));
        pyb = acc(pyb, pos_change(vyb));
        vxa = acc(vxa, dvxa);
        vya = acc(vya, dvya);
        vxb = acc(vxb, dvxb);
        vyb = acc(vyb, dvyb);
        pending_forces = {pending_forces, w};
    endtask

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Sends one step word; valid stays high when no gap follows.
    task automatic send_step(input logic go);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            step_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_ch.valid <= 1'b1;
        step_ch.step_go <= go;
        do
            @(posedge clk);
        while (!step_ch.ready);
        if (go)
            euler_tick();
    endtask

    task automatic drain_forces();
        step_ch.valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_MASS_A: m_a = val;
            REG_MASS_B: m_b = val;
            REG_GRAV:   g_k = val;
            REG_STEP:   h_dt = val;
            default: ;
        endcase
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value(input bit allow_zero);
        case ($urandom_range(0, 7))
            0: return allow_zero ? '0 : 31'd1;
            1: return 31'd1;
            2: return REG_TOP;
            3: return 31'd65536;
            4: return CFG_W'($urandom_range(1, 20000));
            5: return CFG_W'($urandom_range(1, 65536 * 4));
            default: return CFG_W'($urandom()) & REG_TOP;
        endcase
    endfunction

    // Force word return with random backpressure.
    initial
    begin
        int stall;
        force_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(recv_burst);
            if (stall > 0)
            begin
                force_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            force_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!force_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        force_word_t want;
        if (rst_n && force_ch.valid && force_ch.ready)
        begin
            if (pending_forces.size() == 0)
            begin
                $error("force word with none expected");
                fail_count++;
            end
            else
            begin
                want = pending_forces.pop_front();
                if (force_ch.force_x !== want.fx)
                begin
                    $error("force_x expected %0d actual %0d", want.fx, force_ch.force_x);
                    fail_count++;
                end
                if (force_ch.force_y !== want.fy)
                begin
                    $error("force_y expected %0d actual %0d", want.fy, force_ch.force_y);
                    fail_count++;
                end
                if (force_ch.coincident !== want.coin)
                begin
                    $error("coincident expected %0b actual %0b", want.coin,
                           force_ch.coincident);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((step_ch.valid && step_ch.ready) || (force_ch.valid && force_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_step(1'b1);
        send_step(1'b1);
        drain_forces();
    endtask

    // Collides the particles: with h = 1.0 and unit masses, a force of -0.5 on
    // each axis pulls b toward a and moves both half the gap in the second tick.
    task automatic test_coincident();
        force_word_t w;
        logic [CFG_W-1:0] g;
        logic [CFG_W-1:0] found;
        found = 31'd92682;
        for (g = 31'd88000; g < 31'd97000; g++)
        begin
            w = pair_force(g, m_a, m_b, pxa, pya, pxb, pyb);
            if (w.fx == -32'sd32768 && w.fy == -32'sd32768)
            begin
                found = g;
                break;
            end
        end
        write_reg(REG_GRAV, found);
        write_reg(REG_STEP, 31'd65536);
        repeat (4) send_step(1'b1);
        drain_forces();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_MASS_A, REG_TOP);
        write_reg(REG_MASS_B, REG_TOP);
        write_reg(REG_GRAV, REG_TOP);
        write_reg(REG_STEP, REG_TOP);
        repeat (3) send_step(1'b1);
        drain_forces();
        write_reg(REG_GRAV, '0);
        write_reg(REG_STEP, 31'd1);
        repeat (2) send_step(1'b1);
        drain_forces();
        // A zero mass divides as if it held the smallest nonzero mass.
        write_reg(REG_MASS_A, '0);
        write_reg(REG_MASS_B, '0);
        write_reg(REG_GRAV, 31'd65536);
        write_reg(REG_STEP, '0);
        repeat (2) send_step(1'b1);
        drain_forces();
    endtask

    task automatic test_idle_requests();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        drain_forces();
    endtask

    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 11; phase++)
        begin
            write_reg(REG_MASS_A, pick_reg_value(1'b1));
            write_reg(REG_MASS_B, pick_reg_value(1'b1));
            write_reg(REG_GRAV, pick_reg_value(1'b1));
            write_reg(REG_STEP, pick_reg_value(1'b1));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 60; n++)
            begin
                send_step($urandom_range(0, 9) != 0);
                // Hold off once, midway through phase 5, until every force word is back.
                if (phase == 5 && n == 30)
                begin
                    step_ch.valid <= 1'b0;
                    while (pending_forces.size() != 0)
                        @(posedge clk);
                end
            end
            drain_forces();
        end
        send_burst = 1'b0;
        recv_burst = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        step_ch.valid <= 1'b0;
        step_ch.step_go <= 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        m_a = MASS_RST;
        m_b = MASS_RST;
        g_k = GRAV_RST;
        h_dt = STEP_RST;
        pxa = POS_A_RST;
        pya = POS_A_RST;
        pxb = POS_B_RST;
        pyb = POS_B_RST;
        vxa = '0;
        vya = '0;
        vxb = '0;
        vyb = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coincident();
        test_reset_state();
        test_idle_requests();
        test_config_extremes();
        test_random();

        if (fail_count == 0 && pending_forces.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* two_body_gravity_euler_step_top.f */
+incdir+sv
sv/tbge_pkg.sv
sv/tbge_ifs.sv
sv/two_body_gravity_euler_step_top.sv
sv/tbge_checker.sv
bench/testbench.sv
